// ===== hdl/ctp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared codes for the circle tangent point unit: register indexes, turning
// sense codes and the result status.
// ----------------------------------------------------------------------------
package ctp_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_CENTER_X   = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y   = 2'd1;
   localparam logic [1:0] CSR_RADIUS     = 2'd2;
   localparam logic [1:0] CSR_TURN_SENSE = 2'd3;

   // turning sense codes; anything else is unclassified
   localparam logic [1:0] SENSE_CCW = 2'd0;
   localparam logic [1:0] SENSE_CW  = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INSIDE    = 2'd1,
      STATUS_BAD_SENSE = 2'd2
   } status_type;

endpackage

// ===== hdl/ctp_isqrt.sv =====
// ----------------------------------------------------------------------------
// ctp_isqrt
// Pipelined integer square root, one root bit per stage. The side vector
// travels with each radicand.
// ----------------------------------------------------------------------------
module ctp_isqrt #(
   parameter int RW = 33,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);

   logic            vld_ff  [RW];
   logic [RW:0]     rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [2*RW-1:0] rad_ff  [RW];
   logic [SW-1:0]   side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic            vld_i;
      logic [RW:0]     rem_i;
      logic [RW-1:0]   root_i;
      logic [2*RW-1:0] rad_i;
      logic [SW-1:0]   side_i;
      logic [RW+2:0]   cur;
      logic [RW+3:0]   diff;
      logic            ge;

      if (k == 0) begin : g_first
         assign vld_i  = in_valid;
         assign rem_i  = '0;
         assign root_i = '0;
         assign rad_i  = in_rad;
         assign side_i = in_side;
      end else begin : g_next
         assign vld_i  = vld_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign rad_i  = rad_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      // bring down two radicand bits and try root*4+1
      assign cur  = {rem_i, rad_i[2*RW-1 -: 2]};
      assign diff = {1'b0, cur} - {2'b00, root_i, 2'b01};
      assign ge   = !diff[RW+3];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? diff[RW:0] : cur[RW:0];
            root_ff[k] <= {root_i[RW-2:0], ge};
            rad_ff[k]  <= rad_i << 2;
            side_ff[k] <= side_i;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

// ===== hdl/ctp_div.sv =====
// ----------------------------------------------------------------------------
// ctp_div
// Pipelined restoring divider, one quotient bit per stage, with a final
// stage that rounds to nearest, ties away from zero. The quotient is known
// to fit in QW bits.
// ----------------------------------------------------------------------------
module ctp_div #(
   parameter int NW = 98,
   parameter int DW = 65,
   parameter int QW = 34,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW:0]   out_quot,
   output logic [SW-1:0] out_side
);

   logic          vld_ff  [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   logic          out_valid_ff;
   logic [QW:0]   out_quot_ff;
   logic [SW-1:0] out_side_ff;
   logic [DW:0]   twice;
   logic          round_up;

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic          vld_i;
      logic [DW-1:0] rem_i;
      logic [QW-1:0] low_i;
      logic [QW-1:0] quo_i;
      logic [DW-1:0] den_i;
      logic [SW-1:0] side_i;
      logic [DW:0]   trial;
      logic [DW+1:0] diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign vld_i  = in_valid;
         assign rem_i  = DW'(in_num[NW-1:QW]);
         assign low_i  = in_num[QW-1:0];
         assign quo_i  = '0;
         assign den_i  = in_den;
         assign side_i = in_side;
      end else begin : g_next
         assign vld_i  = vld_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign low_i  = low_ff[k-1];
         assign quo_i  = quo_ff[k-1];
         assign den_i  = den_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign trial = {rem_i, low_i[QW-1]};
      assign diff  = {1'b0, trial} - {2'b00, den_i};
      assign ge    = !diff[DW+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[k]  <= low_i << 1;
            quo_ff[k]  <= {quo_i[QW-2:0], ge};
            den_ff[k]  <= den_i;
            side_ff[k] <= side_i;
         end
      end
   end

   // round: bump when twice the remainder reaches the divisor
   assign twice    = {rem_ff[QW-1], 1'b0};
   assign round_up = twice >= {1'b0, den_ff[QW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_quot_ff <= (QW+1)'(quo_ff[QW-1]) + (QW+1)'(round_up);
         out_side_ff <= side_ff[QW-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = out_quot_ff;
   assign out_side  = out_side_ff;

endmodule

// ===== hdl/circle_tangent_point_unit.sv =====
// ----------------------------------------------------------------------------
// circle_tangent_point_unit
// Tangent point from a query point to a configured circle, fixed point.
// ----------------------------------------------------------------------------
// Takes one point per cycle while the result side does not stall and returns one
// result beat per point, in order. The pipe is made of the bit-per-stage square
// root (COORD_WIDTH+1 stages), the bit-per-stage dividers (COORD_WIDTH+2 stages
// plus rounding) and nine stages for all other work. A stall on the result side
// freezes the whole pipe.
// Circle and sense registers must only be written while no point is in flight.
module circle_tangent_point_unit import ctp_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_tangent_x,
   output logic signed [COORD_WIDTH-1:0] rsp_tangent_y,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);

   localparam int W   = COORD_WIDTH;
   localparam int DW  = 2*W + 1;   // squared distance
   localparam int RW  = W + 1;     // leg root
   localparam int QRW = 2*W;       // root times radius
   localparam int NW  = 3*W + 2;   // numerators
   localparam int QW  = W + 2;     // quotient bits
   localparam int TW  = W + 5;     // placement sum
   localparam int SQW = 4*W + 2 + 2*DW + 3;
   localparam int DXW = 2*W + 4;
   localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

   // signed-magnitude add: {sign, magnitude}
   function automatic logic [NW:0] sm_add(logic an, logic [NW-1:0] a,
                                          logic bn, logic [NW-1:0] b);
      logic [NW:0] ab;
      logic [NW:0] ba;
      ab = {1'b0, a} - {1'b0, b};
      ba = {1'b0, b} - {1'b0, a};
      if (an == bn) begin
         return {an, a + b};
      end else if (!ab[NW]) begin
         return {an, ab[NW-1:0]};
      end
      return {bn, ba[NW-1:0]};
   endfunction

   // p plus or minus mag, saturated to the coordinate range
   function automatic logic [W-1:0] place(logic signed [W-1:0] p, logic neg,
                                          logic [QW:0] mag);
      logic signed [TW-1:0] pe;
      logic signed [TW-1:0] me;
      logic signed [TW-1:0] t;
      pe = TW'(p);
      me = signed'(TW'(mag));
      t  = neg ? pe - me : pe + me;
      if (t > TW'(CMAX)) begin
         return CMAX;
      end else if (t < TW'(CMIN)) begin
         return CMIN;
      end
      return t[W-1:0];
   endfunction

   // configuration registers
   logic signed [W-1:0] cx_ff, cy_ff;
   logic [W-2:0]        r_ff;
   logic [1:0]          sense_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff    <= '0;
         cy_ff    <= '0;
         r_ff     <= '0;
         sense_ff <= SENSE_CCW;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CENTER_X:   cx_ff    <= csr_wdata;
            CSR_CENTER_Y:   cy_ff    <= csr_wdata;
            CSR_RADIUS:     r_ff     <= csr_wdata[W-2:0];
            CSR_TURN_SENSE: sense_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // whole pipe advances unless a finished beat is held at the output
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // stage 1: offset to center, split into sign and magnitude
   logic signed [W:0]   dx_in, dy_in;
   logic                s1_vld_ff, s1_xn_ff, s1_yn_ff;
   logic signed [W-1:0] s1_px_ff, s1_py_ff;
   logic [W-1:0]        s1_ax_ff, s1_ay_ff;
   logic [W:0]          ndx, ndy;

   assign dx_in = (W+1)'(cx_ff) - (W+1)'(req_point_x);
   assign dy_in = (W+1)'(cy_ff) - (W+1)'(req_point_y);
   assign ndx   = -dx_in;
   assign ndy   = -dy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff <= req_point_x;
         s1_py_ff <= req_point_y;
         s1_xn_ff <= dx_in[W];
         s1_yn_ff <= dy_in[W];
         s1_ax_ff <= dx_in[W] ? ndx[W-1:0] : dx_in[W-1:0];
         s1_ay_ff <= dy_in[W] ? ndy[W-1:0] : dy_in[W-1:0];
      end
   end

   // stage 2: squares
   logic                s2_vld_ff, s2_xn_ff, s2_yn_ff;
   logic signed [W-1:0] s2_px_ff, s2_py_ff;
   logic [W-1:0]        s2_ax_ff, s2_ay_ff;
   logic [2*W-1:0]      s2_dx2_ff, s2_dy2_ff, s2_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_xn_ff  <= s1_xn_ff;
         s2_yn_ff  <= s1_yn_ff;
         s2_ax_ff  <= s1_ax_ff;
         s2_ay_ff  <= s1_ay_ff;
         s2_dx2_ff <= (2*W)'(s1_ax_ff) * (2*W)'(s1_ax_ff);
         s2_dy2_ff <= (2*W)'(s1_ay_ff) * (2*W)'(s1_ay_ff);
         s2_r2_ff  <= (2*W)'(r_ff) * (2*W)'(r_ff);
      end
   end

   // stage 3: squared distance
   logic                s3_vld_ff, s3_xn_ff, s3_yn_ff;
   logic signed [W-1:0] s3_px_ff, s3_py_ff;
   logic [W-1:0]        s3_ax_ff, s3_ay_ff;
   logic [DW-1:0]       s3_d_ff;
   logic [2*W-1:0]      s3_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_px_ff <= s2_px_ff;
         s3_py_ff <= s2_py_ff;
         s3_xn_ff <= s2_xn_ff;
         s3_yn_ff <= s2_yn_ff;
         s3_ax_ff <= s2_ax_ff;
         s3_ay_ff <= s2_ay_ff;
         s3_d_ff  <= DW'(s2_dx2_ff) + DW'(s2_dy2_ff);
         s3_r2_ff <= s2_r2_ff;
      end
   end

   // stage 4: leg square and classification
   logic [DW:0]         leg_in;
   logic                on_in;
   status_type          status_in;
   logic                s4_vld_ff, s4_xn_ff, s4_yn_ff, s4_on_ff;
   logic signed [W-1:0] s4_px_ff, s4_py_ff;
   logic [W-1:0]        s4_ax_ff, s4_ay_ff;
   logic [DW-1:0]       s4_d_ff, s4_l_ff;
   status_type          s4_status_ff;

   assign leg_in = {1'b0, s3_d_ff} - (DW+1)'(s3_r2_ff);

   always_comb begin
      on_in     = 1'b0;
      status_in = STATUS_OK;
      if (leg_in[DW]) begin
         status_in = STATUS_INSIDE;
      end else if (leg_in[DW-1:0] == '0) begin
         on_in = 1'b1;
      end else if (sense_ff != SENSE_CCW && sense_ff != SENSE_CW) begin
         status_in = STATUS_BAD_SENSE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_px_ff     <= s3_px_ff;
         s4_py_ff     <= s3_py_ff;
         s4_xn_ff     <= s3_xn_ff;
         s4_yn_ff     <= s3_yn_ff;
         s4_ax_ff     <= s3_ax_ff;
         s4_ay_ff     <= s3_ay_ff;
         s4_d_ff      <= s3_d_ff;
         s4_l_ff      <= leg_in[DW-1:0];
         s4_on_ff     <= on_in;
         s4_status_ff <= status_in;
      end
   end

   // square root of the leg square
   logic            sq_vld;
   logic [RW-1:0]   sq_root;
   logic [SQW-1:0]  sq_side_in, sq_side;
   logic signed [W-1:0] u_px, u_py;
   logic            u_xn, u_yn, u_on;
   logic [W-1:0]    u_ax, u_ay;
   logic [DW-1:0]   u_d, u_l;
   logic [1:0]      u_st;

   assign sq_side_in = {s4_px_ff, s4_py_ff, s4_xn_ff, s4_yn_ff, s4_ax_ff, s4_ay_ff,
                        s4_d_ff, s4_l_ff, s4_status_ff, s4_on_ff};
   assign {u_px, u_py, u_xn, u_yn, u_ax, u_ay, u_d, u_l, u_st, u_on} = sq_side;

   ctp_isqrt #(
      .RW (RW),
      .SW (SQW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_vld_ff),
      .in_rad    ((2*RW)'(s4_l_ff)),
      .in_side   (sq_side_in),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage 5: root times radius
   logic                s5_vld_ff, s5_xn_ff, s5_yn_ff, s5_on_ff;
   logic signed [W-1:0] s5_px_ff, s5_py_ff;
   logic [W-1:0]        s5_ax_ff, s5_ay_ff;
   logic [DW-1:0]       s5_d_ff, s5_l_ff;
   logic [1:0]          s5_st_ff;
   logic [QRW-1:0]      s5_qr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (advance) begin
         s5_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_px_ff <= u_px;
         s5_py_ff <= u_py;
         s5_xn_ff <= u_xn;
         s5_yn_ff <= u_yn;
         s5_ax_ff <= u_ax;
         s5_ay_ff <= u_ay;
         s5_d_ff  <= u_d;
         s5_l_ff  <= u_l;
         s5_st_ff <= u_st;
         s5_on_ff <= u_on;
         s5_qr_ff <= QRW'(sq_root) * QRW'(r_ff);
      end
   end

   // stage 6: partial products on split halves
   logic                s6_vld_ff, s6_xn_ff, s6_yn_ff, s6_on_ff;
   logic signed [W-1:0] s6_px_ff, s6_py_ff;
   logic [DW-1:0]       s6_d_ff;
   logic [1:0]          s6_st_ff;
   logic [2*W-1:0]      s6_axl_lo_ff, s6_ayl_lo_ff;
   logic [2*W:0]        s6_axl_hi_ff, s6_ayl_hi_ff;
   logic [2*W-1:0]      s6_axq_lo_ff, s6_axq_hi_ff, s6_ayq_lo_ff, s6_ayq_hi_ff;
   logic [W-1:0]        l_lo, q_lo, q_hi;
   logic [W:0]          l_hi;

   assign l_lo = s5_l_ff[W-1:0];
   assign l_hi = s5_l_ff[DW-1:W];
   assign q_lo = s5_qr_ff[W-1:0];
   assign q_hi = s5_qr_ff[QRW-1:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (advance) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_px_ff     <= s5_px_ff;
         s6_py_ff     <= s5_py_ff;
         s6_xn_ff     <= s5_xn_ff;
         s6_yn_ff     <= s5_yn_ff;
         s6_d_ff      <= s5_d_ff;
         s6_st_ff     <= s5_st_ff;
         s6_on_ff     <= s5_on_ff;
         s6_axl_lo_ff <= (2*W)'(s5_ax_ff) * (2*W)'(l_lo);
         s6_axl_hi_ff <= (2*W+1)'(s5_ax_ff) * (2*W+1)'(l_hi);
         s6_ayl_lo_ff <= (2*W)'(s5_ay_ff) * (2*W)'(l_lo);
         s6_ayl_hi_ff <= (2*W+1)'(s5_ay_ff) * (2*W+1)'(l_hi);
         s6_axq_lo_ff <= (2*W)'(s5_ax_ff) * (2*W)'(q_lo);
         s6_axq_hi_ff <= (2*W)'(s5_ax_ff) * (2*W)'(q_hi);
         s6_ayq_lo_ff <= (2*W)'(s5_ay_ff) * (2*W)'(q_lo);
         s6_ayq_hi_ff <= (2*W)'(s5_ay_ff) * (2*W)'(q_hi);
      end
   end

   // stage 7: combine halves into full products
   logic                s7_vld_ff, s7_xn_ff, s7_yn_ff, s7_on_ff;
   logic signed [W-1:0] s7_px_ff, s7_py_ff;
   logic [DW-1:0]       s7_d_ff;
   logic [1:0]          s7_st_ff;
   logic [NW-1:0]       s7_tx1_ff, s7_tx2_ff, s7_ty1_ff, s7_ty2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (advance) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_px_ff  <= s6_px_ff;
         s7_py_ff  <= s6_py_ff;
         s7_xn_ff  <= s6_xn_ff;
         s7_yn_ff  <= s6_yn_ff;
         s7_d_ff   <= s6_d_ff;
         s7_st_ff  <= s6_st_ff;
         s7_on_ff  <= s6_on_ff;
         s7_tx1_ff <= (NW'(s6_axl_hi_ff) << W) + NW'(s6_axl_lo_ff);
         s7_tx2_ff <= (NW'(s6_ayq_hi_ff) << W) + NW'(s6_ayq_lo_ff);
         s7_ty1_ff <= (NW'(s6_axq_hi_ff) << W) + NW'(s6_axq_lo_ff);
         s7_ty2_ff <= (NW'(s6_ayl_hi_ff) << W) + NW'(s6_ayl_lo_ff);
      end
   end

   // stage 8: signed numerators, sense picks the tangent side
   logic                ccw;
   logic [NW:0]         nx_in, ny_in;
   logic                s8_vld_ff, s8_nxs_ff, s8_nys_ff, s8_on_ff;
   logic signed [W-1:0] s8_px_ff, s8_py_ff;
   logic [DW-1:0]       s8_d_ff;
   logic [1:0]          s8_st_ff;
   logic [NW-1:0]       s8_nx_ff, s8_ny_ff;

   assign ccw   = (sense_ff == SENSE_CCW);
   assign nx_in = sm_add(s7_xn_ff, s7_tx1_ff, ccw ? !s7_yn_ff : s7_yn_ff, s7_tx2_ff);
   assign ny_in = sm_add(ccw ? s7_xn_ff : !s7_xn_ff, s7_ty1_ff, s7_yn_ff, s7_ty2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (advance) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_px_ff  <= s7_px_ff;
         s8_py_ff  <= s7_py_ff;
         s8_d_ff   <= s7_d_ff;
         s8_st_ff  <= s7_st_ff;
         s8_on_ff  <= s7_on_ff;
         s8_nxs_ff <= nx_in[NW];
         s8_nys_ff <= ny_in[NW];
         s8_nx_ff  <= nx_in[NW-1:0];
         s8_ny_ff  <= ny_in[NW-1:0];
      end
   end

   // divide both numerators by the squared distance
   logic                dvx_vld, dvy_vld;
   logic [QW:0]         dvx_quot, dvy_quot;
   logic [DXW-1:0]      dvx_side;
   logic                dvy_side;
   logic signed [W-1:0] v_px, v_py;
   logic                v_nxs, v_on;
   logic [1:0]          v_st;

   assign {v_px, v_py, v_nxs, v_st, v_on} = dvx_side;

   ctp_div #(
      .NW (NW),
      .DW (DW),
      .QW (QW),
      .SW (DXW)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s8_vld_ff),
      .in_num    (s8_nx_ff),
      .in_den    (s8_d_ff),
      .in_side   ({s8_px_ff, s8_py_ff, s8_nxs_ff, s8_st_ff, s8_on_ff}),
      .out_valid (dvx_vld),
      .out_quot  (dvx_quot),
      .out_side  (dvx_side)
   );

   ctp_div #(
      .NW (NW),
      .DW (DW),
      .QW (QW),
      .SW (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s8_vld_ff),
      .in_num    (s8_ny_ff),
      .in_den    (s8_d_ff),
      .in_side   (s8_nys_ff),
      .out_valid (dvy_vld),
      .out_quot  (dvy_quot),
      .out_side  (dvy_side)
   );

   // output register: place the offsets and pick by status
   logic [W-1:0] tx_in, ty_in;
   logic [W-1:0] rsp_tx_ff, rsp_ty_ff;
   logic [1:0]   rsp_st_ff;

   always_comb begin
      tx_in = '0;
      ty_in = '0;
      if (v_st == STATUS_OK) begin
         if (v_on) begin
            tx_in = v_px;
            ty_in = v_py;
         end else begin
            tx_in = place(v_px, v_nxs, dvx_quot);
            ty_in = place(v_py, dvy_side, dvy_quot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dvx_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tx_ff <= tx_in;
         rsp_ty_ff <= ty_in;
         rsp_st_ff <= v_st;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tangent_x = rsp_tx_ff;
   assign rsp_tangent_y = rsp_ty_ff;
   assign rsp_status    = rsp_st_ff;

   // checks
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_INSIDE |-> rsp_tangent_x == '0 && rsp_tangent_y == '0)
      else $error("inside point gave a nonzero tangent");

   a_bad_sense: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_SENSE
         |-> sense_ff != SENSE_CCW && sense_ff != SENSE_CW && rsp_tangent_x == '0)
      else $error("bad sense status without an unclassified sense");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dvx_vld == dvy_vld)
      else $error("divider lanes out of step");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

endmodule

// ===== test/tb_circle_tangent_point_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_tangent_point_unit
// Self-checking bench for the circle tangent point unit.
// ----------------------------------------------------------------------------
// Walks a table of directed points (reset circle, points inside, on and
// outside the circle, coordinate extremes, every turning sense), then runs
// phases of random points under random circles. Each result beat is compared
// with the table's expected value or with a wide-integer model of the tangent construction. The
// sender idles in bursts, and the receiver stalls on its own pattern,
// including one long hold-off that backs up the pipe.
// ----------------------------------------------------------------------------
module tb_circle_tangent_point_unit import ctp_pkg::*; ();

   localparam int W = 32;
   localparam int DRAIN_CYCLES = 2 * W + 13 + 20;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_PHASES = 8;
   localparam int POINTS_PER_PHASE = 240;
   localparam int DIRECTED_CIRCLES = 9;

   typedef logic signed [199:0] wide_s_type;
   typedef logic [191:0] wide_u_type;

   typedef struct {
      logic signed [W-1:0] tx;
      logic signed [W-1:0] ty;
      status_type          status;
   } tangent_type;

   typedef struct {
      logic signed [W-1:0] cx;
      logic signed [W-1:0] cy;
      logic [W-2:0]        r;
      logic [1:0]          sense;
      logic signed [W-1:0] px;
      logic signed [W-1:0] py;
      bit                  typed;
      tangent_type         want;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [W-1:0] req_point_x = '0;
   logic signed [W-1:0] req_point_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [W-1:0] rsp_tangent_x;
   logic signed [W-1:0] rsp_tangent_y;
   logic [1:0]          rsp_status;
   logic                csr_write = 1'b0;
   logic [1:0]          csr_index = CSR_CENTER_X;
   logic [W-1:0]        csr_wdata = '0;

   // circle as the bench believes it is programmed
   logic signed [W-1:0] circ_cx = '0;
   logic signed [W-1:0] circ_cy = '0;
   logic [W-2:0]        circ_r = '0;
   logic [1:0]          circ_sense = SENSE_CCW;

   tangent_type pending_tangents[$];
   int          mismatches = 0;
   int          points_sent = 0;
   int          beats_checked = 0;
   int          outside_ok = 0;
   int          inside_seen = 0;
   int          bad_sense_seen = 0;
   int          cycles = 0;
   int          burst_left = 0;
   bit          hold_off = 1'b0;

   directed_row_type dir_rows[$];

   circle_tangent_point_unit #(.COORD_WIDTH(W)) u_dut (.*);

   always #2 clock = ~clock;

   // floor square root of a wide value
   function automatic logic [63:0] floor_sqrt(input wide_u_type v);
      logic [63:0] root;
      logic [63:0] cand;
      wide_u_type  sq;
      root = '0;
      for (int b = 40; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         sq = wide_u_type'(cand) * wide_u_type'(cand);
         if (sq <= v) root = cand;
      end
      return root;
   endfunction

   // quotient rounded to nearest, ties away from zero, then added and clamped
   function automatic logic signed [W-1:0] place_coord(input logic signed [W-1:0] p,
                                                       input wide_s_type num,
                                                       input wide_u_type den);
      wide_u_type mag;
      wide_u_type quo;
      wide_u_type rem;
      longint     t;
      longint     hi;
      longint     lo;
      mag = (num < 0) ? wide_u_type'(-num) : wide_u_type'(num);
      quo = mag / den;
      rem = mag - quo * den;
      if ((rem << 1) >= den) quo = quo + 1;
      t = (num < 0) ? longint'(p) - longint'(quo[63:0]) : longint'(p) + longint'(quo[63:0]);
      hi = (longint'(1) <<< (W - 1)) - 1;
      lo = -hi - 1;
      if (t > hi) t = hi;
      if (t < lo) t = lo;
      return t[W-1:0];
   endfunction

   function automatic tangent_type tangent_of(input logic signed [W-1:0] px,
                                              input logic signed [W-1:0] py);
      tangent_type res;
      longint      dx;
      longint      dy;
      wide_s_type  sdx;
      wide_s_type  sdy;
      wide_s_type  sgn;
      wide_s_type  nx;
      wide_s_type  ny;
      wide_u_type  dd;
      wide_u_type  r2;
      wide_u_type  leg;
      wide_u_type  qr;
      dx = longint'(circ_cx) - longint'(px);
      dy = longint'(circ_cy) - longint'(py);
      sdx = dx;
      sdy = dy;
      dd = wide_u_type'(sdx * sdx + sdy * sdy);
      r2 = wide_u_type'(circ_r) * wide_u_type'(circ_r);
      res.tx = '0;
      res.ty = '0;
      res.status = STATUS_OK;
      if (dd < r2) begin
         res.status = STATUS_INSIDE;
      end else if (dd == r2) begin
         res.tx = px;
         res.ty = py;
      end else if (circ_sense != SENSE_CCW && circ_sense != SENSE_CW) begin
         res.status = STATUS_BAD_SENSE;
      end else begin
         leg = dd - r2;
         qr = wide_u_type'(floor_sqrt(leg)) * wide_u_type'(circ_r);
         sgn = (circ_sense == SENSE_CCW) ? 200'sd1 : -200'sd1;
         nx = sdx * wide_s_type'(leg) - sgn * sdy * wide_s_type'(qr);
         ny = sgn * sdx * wide_s_type'(qr) + sdy * wide_s_type'(leg);
         res.tx = place_coord(px, nx, dd);
         res.ty = place_coord(py, ny, dd);
      end
      return res;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stall pattern: quiet stretches, light and heavy stalling, hold-off
   always @(posedge clock) begin
      case (cycles[10:9])
         2'd0: rsp_stall <= hold_off;
         2'd1: rsp_stall <= hold_off || ($urandom_range(0, 99) < 25);
         2'd2: rsp_stall <= hold_off || ($urandom_range(0, 99) < 70);
         default: rsp_stall <= hold_off || ($urandom_range(0, 99) < 5);
      endcase
   end

   // long hold-off once traffic is flowing, so the pipe fills and stalls input
   initial begin
      wait (points_sent > 400);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   // compare each result beat with the oldest expected tangent
   always @(posedge clock) begin
      tangent_type exp_t;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tangents.size() == 0) begin
            $error("result beat with no point outstanding");
            mismatches++;
         end else begin
            exp_t = pending_tangents.pop_front();
            beats_checked++;
            if (rsp_tangent_x !== exp_t.tx) begin
               $error("tangent_x expected %0d actual %0d", exp_t.tx, rsp_tangent_x);
               mismatches++;
            end
            if (rsp_tangent_y !== exp_t.ty) begin
               $error("tangent_y expected %0d actual %0d", exp_t.ty, rsp_tangent_y);
               mismatches++;
            end
            if (rsp_status !== exp_t.status) begin
               $error("status expected %0d actual %0d", exp_t.status, rsp_status);
               mismatches++;
            end
            case (exp_t.status)
               STATUS_OK: outside_ok++;
               STATUS_INSIDE: inside_seen++;
               default: bad_sense_seen++;
            endcase
         end
      end
   end

   // offer one point beat; idle between bursts; record the expectation on accept
   task automatic send_point(input logic signed [W-1:0] px, input logic signed [W-1:0] py,
                             input bit typed, input tangent_type want);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_tangents.insert(pending_tangents.size(), typed ? want : tangent_of(px, py));
      points_sent++;
      burst_left--;
   endtask

   // drain, then program the circle; also pokes ignored upper data bits
   task automatic set_circle(input logic signed [W-1:0] cx, input logic signed [W-1:0] cy,
                             input logic [W-2:0] r, input logic [1:0] sense);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_tangents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= cx;
      @(posedge clock);
      csr_index <= CSR_CENTER_Y;
      csr_wdata <= cy;
      @(posedge clock);
      csr_index <= CSR_RADIUS;
      csr_wdata <= {1'($urandom), r};
      @(posedge clock);
      csr_index <= CSR_TURN_SENSE;
      csr_wdata <= {30'($urandom), sense};
      @(posedge clock);
      csr_write <= 1'b0;
      circ_cx = cx;
      circ_cy = cy;
      circ_r = r;
      circ_sense = sense;
   endtask

   function automatic logic signed [W-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(W-1){1'b1}}};
         1: return {1'b1, {(W-1){1'b0}}};
         2: return W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         default: return W'($urandom);
      endcase
   endfunction

   function automatic logic [W-2:0] pick_radius();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return {(W-1){1'b1}};
         2: return (W-1)'($urandom_range(1, 1 << 24));
         default: return (W-1)'($urandom);
      endcase
   endfunction

   // append one directed row to the table
   function automatic void add_row(input int cx, input int cy, input int r,
                                   input logic [1:0] sense, input int px, input int py,
                                   input bit typed, input int tx, input int ty,
                                   input status_type st);
      directed_row_type d;
      d.cx = cx;
      d.cy = cy;
      d.r = r[W-2:0];
      d.sense = sense;
      d.px = px;
      d.py = py;
      d.typed = typed;
      d.want.tx = tx;
      d.want.ty = ty;
      d.want.status = st;
      dir_rows.insert(dir_rows.size(), d);
   endfunction

   initial begin
      logic signed [W-1:0] px;
      logic signed [W-1:0] py;
      logic signed [W-1:0] cx;
      logic signed [W-1:0] cy;
      logic [W-2:0]        r;
      longint              ox;
      longint              oy;
      tangent_type         none;
      int                  max_c;
      int                  min_c;
      int                  one;
      max_c = 32'h7fff_ffff;
      min_c = 32'h8000_0000;
      one = 32'h0001_0000;
      none = '{tx: '0, ty: '0, status: STATUS_OK};

      // reset circle: zero radius at the origin, so the origin is on it
      add_row(0, 0, 0, SENSE_CCW, 0, 0, 1, 0, 0, STATUS_OK);
      add_row(0, 0, 0, SENSE_CCW, 5 * one, -3 * one, 0, 0, 0, STATUS_OK);
      // unit circle at the origin
      add_row(0, 0, one, SENSE_CCW, 0, 0, 1, 0, 0, STATUS_INSIDE);
      add_row(0, 0, one, SENSE_CCW, one, 0, 1, one, 0, STATUS_OK);
      add_row(0, 0, one, SENSE_CCW, 0, -one, 1, 0, -one, STATUS_OK);
      add_row(0, 0, one, SENSE_CCW, 2 * one, 0, 0, 0, 0, STATUS_OK);
      add_row(0, 0, one, SENSE_CCW, max_c, max_c, 0, 0, 0, STATUS_OK);
      add_row(0, 0, one, SENSE_CCW, min_c, min_c, 0, 0, 0, STATUS_OK);
      add_row(0, 0, one, SENSE_CCW, max_c, min_c, 0, 0, 0, STATUS_OK);
      add_row(0, 0, one, SENSE_CW, 2 * one, 0, 0, 0, 0, STATUS_OK);
      add_row(0, 0, one, SENSE_CW, -3 * one, one, 0, 0, 0, STATUS_OK);
      add_row(0, 0, one, SENSE_CW, one / 2, 0, 1, 0, 0, STATUS_INSIDE);
      // unclassified sense: fails outside, but inside and on-circle still report
      add_row(0, 0, one, 2'd2, 3 * one, 0, 1, 0, 0, STATUS_BAD_SENSE);
      add_row(0, 0, one, 2'd2, 0, 0, 1, 0, 0, STATUS_INSIDE);
      add_row(0, 0, one, 2'd2, -one, 0, 1, -one, 0, STATUS_OK);
      add_row(0, 0, one, 2'd3, max_c, 0, 1, 0, 0, STATUS_BAD_SENSE);
      // extreme circles: corner centers, mostly the largest radius, saturating tangents
      add_row(max_c, max_c, max_c, SENSE_CCW, min_c, min_c, 0, 0, 0, STATUS_OK);
      add_row(max_c, max_c, max_c, SENSE_CW, min_c, min_c, 0, 0, 0, STATUS_OK);
      add_row(max_c, max_c, max_c, SENSE_CW, max_c, max_c, 1, 0, 0, STATUS_INSIDE);
      add_row(min_c, max_c, max_c, SENSE_CCW, max_c, min_c, 0, 0, 0, STATUS_OK);
      add_row(min_c, min_c, 12345, SENSE_CCW, max_c, max_c, 0, 0, 0, STATUS_OK);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table, reprogramming only when the circle changes
      foreach (dir_rows[i]) begin
         if (dir_rows[i].cx !== circ_cx || dir_rows[i].cy !== circ_cy ||
             dir_rows[i].r !== circ_r || dir_rows[i].sense !== circ_sense)
            set_circle(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].r, dir_rows[i].sense);
         send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].typed, dir_rows[i].want);
      end

      // random circles; points near the circle or anywhere
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         cx = pick_coord();
         cy = pick_coord();
         r = pick_radius();
         set_circle(cx, cy, r, (ph % 4 == 3) ? 2'($urandom_range(2, 3)) : 2'(ph % 2));
         for (int k = 0; k < POINTS_PER_PHASE; k++) begin
            if ($urandom_range(0, 1) == 0) begin
               ox = longint'($signed($urandom)) % (longint'(circ_r) * 3 + 2);
               oy = longint'($signed($urandom)) % (longint'(circ_r) * 3 + 2);
               px = W'(longint'(circ_cx) + ox);
               py = W'(longint'(circ_cy) + oy);
            end else begin
               px = pick_coord();
               py = pick_coord();
            end
            send_point(px, py, 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      while (pending_tangents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d points over %0d circles, %0d beats checked.", points_sent,
               RANDOM_PHASES + DIRECTED_CIRCLES, beats_checked);
      $display("Tangents %0d, inside %0d, unclassified sense %0d.", outside_ok,
               inside_seen, bad_sense_seen);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
